// ----- rtl/heap_sort_engine_top_assert.svh -----
// Assertion macros for the heap sort engine.
`ifndef HEAP_SORT_ENGINE_TOP_ASSERT_SVH
`define HEAP_SORT_ENGINE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define HSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap sort engine: assertion failed");
`define HSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap sort engine: assertion failed");
`else
`define HSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/hse_pkg.sv -----
package hse_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [9:0] {
        S_LOAD      = 10'b0000000001,
        S_BUILD_RD  = 10'b0000000010,
        S_BUILD_V   = 10'b0000000100,
        S_SIFT_RD   = 10'b0000001000,
        S_SIFT_CMP  = 10'b0000010000,
        S_SIFT_MOVE = 10'b0000100000,
        S_SWAP_RD   = 10'b0001000000,
        S_SWAP_WR   = 10'b0010000000,
        S_EMIT_RD   = 10'b0100000000,
        S_EMIT_LD   = 10'b1000000000
    } t_state;

    typedef struct packed {
        logic re;
        logic we;
    } t_mem_ctl;

    typedef struct packed {
        logic load;
        logic last;
        logic ovf;
    } t_out_ctl;

endpackage

// ----- rtl/hse_mem.sv -----
module hse_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                            i_clk,
    input  hse_pkg::t_mem_ctl               i_ctl,
    input  logic [AW-1:0]                   i_ra_a,
    input  logic [AW-1:0]                   i_ra_b,
    input  logic [AW-1:0]                   i_wa,
    input  logic [hse_pkg::DATA_W-1:0]      i_wd,
    output logic [hse_pkg::DATA_W-1:0]      o_rd_a,
    output logic [hse_pkg::DATA_W-1:0]      o_rd_b
);

    logic [hse_pkg::DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            o_rd_a <= r_mem[i_ra_a];
            o_rd_b <= r_mem[i_ra_b];
        end
    end

endmodule

// ----- rtl/hse_seq.sv -----
`include "heap_sort_engine_top_assert.svh"

module hse_seq #(
    parameter int MAX_ELEMENTS = 64,
    parameter int IDX_W        = 6,
    parameter int CNT_W        = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic [hse_pkg::DATA_W-1:0]      i_value,
    input  logic                            i_last_item,
    output logic                            o_in_stall,
    input  logic                            i_out_free,
    output hse_pkg::t_out_ctl               o_out_ctl,
    output hse_pkg::t_mem_ctl               o_mem_ctl,
    output logic [IDX_W-1:0]                o_ra_a,
    output logic [IDX_W-1:0]                o_ra_b,
    output logic [IDX_W-1:0]                o_wa,
    output logic [hse_pkg::DATA_W-1:0]      o_wd,
    input  logic [hse_pkg::DATA_W-1:0]      i_rd_a,
    input  logic [hse_pkg::DATA_W-1:0]      i_rd_b
);

    localparam int J_W = IDX_W + 2;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_ELEMENTS);

    hse_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]           r_count, n_count;
    logic                       r_drop, n_drop;
    logic [CNT_W-1:0]           r_i, n_i;
    logic [CNT_W-1:0]           r_len, n_len;
    logic [CNT_W-1:0]           r_end, n_end;
    logic                       r_ext, n_ext;
    logic [IDX_W-1:0]           r_k, n_k;
    logic [IDX_W-1:0]           r_cidx, n_cidx;
    logic [hse_pkg::DATA_W-1:0] r_v, n_v;
    logic [hse_pkg::DATA_W-1:0] r_cval, n_cval;

    logic [J_W-1:0]   child_j;
    logic [J_W-1:0]   child_j1;
    logic [J_W-1:0]   len_ext;
    logic [CNT_W-1:0] cnt_after;
    logic             sift_done;

    // shared signed compare unit
    logic signed [hse_pkg::DATA_W-1:0] cmp_a;
    logic signed [hse_pkg::DATA_W-1:0] cmp_b;
    logic                              cmp_lt;

    assign child_j   = J_W'({r_k, 1'b1});
    assign child_j1  = child_j + J_W'(1);
    assign len_ext   = J_W'(r_len);
    assign cnt_after = (r_count < CAP) ? r_count + CNT_W'(1) : r_count;

    assign o_in_stall = (r_state != hse_pkg::S_LOAD);

    always_comb begin
        if (r_state == hse_pkg::S_SIFT_CMP) begin
            cmp_a = i_rd_a;
            cmp_b = i_rd_b;
        end else begin
            cmp_a = r_v;
            cmp_b = r_cval;
        end
        cmp_lt = (cmp_a < cmp_b);
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_drop    = r_drop;
        n_i       = r_i;
        n_len     = r_len;
        n_end     = r_end;
        n_ext     = r_ext;
        n_k       = r_k;
        n_cidx    = r_cidx;
        n_v       = r_v;
        n_cval    = r_cval;
        o_mem_ctl = '0;
        o_ra_a    = r_k;
        o_ra_b    = '0;
        o_wa      = r_k;
        o_wd      = r_v;
        o_out_ctl = '0;
        sift_done = 1'b0;

        case (r_state)
            hse_pkg::S_LOAD: begin
                if (i_in_valid) begin
                    if (r_count < CAP) begin
                        o_mem_ctl.we = 1'b1;
                        o_wa         = r_count[IDX_W-1:0];
                        o_wd         = i_value;
                        n_count      = r_count + CNT_W'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last_item) begin
                        if (cnt_after < CNT_W'(2)) begin
                            n_k     = '0;
                            n_state = hse_pkg::S_EMIT_RD;
                        end else begin
                            n_i     = cnt_after >> 1;
                            n_k     = IDX_W'((cnt_after >> 1) - CNT_W'(1));
                            n_len   = cnt_after;
                            n_ext   = 1'b0;
                            n_state = hse_pkg::S_BUILD_RD;
                        end
                    end
                end
            end
            hse_pkg::S_BUILD_RD: begin
                o_mem_ctl.re = 1'b1;
                o_ra_a       = r_k;
                n_state      = hse_pkg::S_BUILD_V;
            end
            hse_pkg::S_BUILD_V: begin
                n_v     = i_rd_a;
                n_state = hse_pkg::S_SIFT_RD;
            end
            hse_pkg::S_SIFT_RD: begin
                if (child_j >= len_ext) begin
                    o_mem_ctl.we = 1'b1;
                    o_wa         = r_k;
                    o_wd         = r_v;
                    sift_done    = 1'b1;
                end else begin
                    o_mem_ctl.re = 1'b1;
                    o_ra_a       = child_j[IDX_W-1:0];
                    o_ra_b       = child_j1[IDX_W-1:0];
                    n_state      = hse_pkg::S_SIFT_CMP;
                end
            end
            hse_pkg::S_SIFT_CMP: begin
                if ((child_j1 < len_ext) && cmp_lt) begin
                    n_cidx = child_j1[IDX_W-1:0];
                    n_cval = i_rd_b;
                end else begin
                    n_cidx = child_j[IDX_W-1:0];
                    n_cval = i_rd_a;
                end
                n_state = hse_pkg::S_SIFT_MOVE;
            end
            hse_pkg::S_SIFT_MOVE: begin
                o_mem_ctl.we = 1'b1;
                o_wa         = r_k;
                if (cmp_lt) begin
                    o_wd    = r_cval;
                    n_k     = r_cidx;
                    n_state = hse_pkg::S_SIFT_RD;
                end else begin
                    o_wd      = r_v;
                    sift_done = 1'b1;
                end
            end
            hse_pkg::S_SWAP_RD: begin
                o_mem_ctl.re = 1'b1;
                o_ra_a       = '0;
                o_ra_b       = r_end[IDX_W-1:0];
                n_state      = hse_pkg::S_SWAP_WR;
            end
            hse_pkg::S_SWAP_WR: begin
                // old root parks at the end; old last entry sifts from the root
                o_mem_ctl.we = 1'b1;
                o_wa         = r_end[IDX_W-1:0];
                o_wd         = i_rd_a;
                n_v          = i_rd_b;
                n_k          = '0;
                n_len        = r_end;
                n_state      = hse_pkg::S_SIFT_RD;
            end
            hse_pkg::S_EMIT_RD: begin
                if (i_out_free) begin
                    o_mem_ctl.re = 1'b1;
                    o_ra_a       = r_k;
                    n_state      = hse_pkg::S_EMIT_LD;
                end
            end
            hse_pkg::S_EMIT_LD: begin
                o_out_ctl.load = 1'b1;
                o_out_ctl.last = (CNT_W'(r_k) == r_count - CNT_W'(1));
                o_out_ctl.ovf  = r_drop;
                if (o_out_ctl.last) begin
                    n_count = '0;
                    n_drop  = 1'b0;
                    n_state = hse_pkg::S_LOAD;
                end else begin
                    n_k     = r_k + IDX_W'(1);
                    n_state = hse_pkg::S_EMIT_RD;
                end
            end
            default: begin
                n_state = hse_pkg::S_LOAD;
            end
        endcase

        if (sift_done) begin
            if (!r_ext) begin
                if (r_i > CNT_W'(1)) begin
                    n_i     = r_i - CNT_W'(1);
                    n_k     = IDX_W'(r_i - CNT_W'(2));
                    n_state = hse_pkg::S_BUILD_RD;
                end else begin
                    n_ext   = 1'b1;
                    n_end   = r_len - CNT_W'(1);
                    n_state = hse_pkg::S_SWAP_RD;
                end
            end else begin
                if (r_end == CNT_W'(1)) begin
                    n_k     = '0;
                    n_state = hse_pkg::S_EMIT_RD;
                end else begin
                    n_end   = r_end - CNT_W'(1);
                    n_state = hse_pkg::S_SWAP_RD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hse_pkg::S_LOAD;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_ext   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
            r_ext   <= n_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_len  <= n_len;
        r_end  <= n_end;
        r_k    <= n_k;
        r_cidx <= n_cidx;
        r_v    <= n_v;
        r_cval <= n_cval;
    end

    `HSE_ASSERT_IMP(a_child_in_heap, i_clk, i_rst_n, r_state == hse_pkg::S_SIFT_CMP, child_j < len_ext)
    `HSE_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CAP)
    `HSE_ASSERT_NXT(a_set_closed, i_clk, i_rst_n, o_out_ctl.load && o_out_ctl.last, (r_state == hse_pkg::S_LOAD) && (r_count == '0) && !r_drop)

endmodule

// ----- rtl/heap_sort_engine_top.sv -----
// Load: input beats are taken while o_in_stall is low; the beat marked last starts the sort.
// Sort: bottom-up heap build, then n-1 root swaps, each sift level done in
// three steps (child read, child compare, move) on one shared comparator.
// Output: each sorted beat is read from the heap memory read port into the output register.
// Synchronous active-low reset clears control; heap memory is not cleared.
`include "heap_sort_engine_top_assert.svh"

module heap_sort_engine_top #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [hse_pkg::DATA_W-1:0] i_value,
    input  logic                            i_last_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [hse_pkg::DATA_W-1:0] o_sorted_value,
    output logic                            o_last_out,
    output logic                            o_overflowed
);

    localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    hse_pkg::t_out_ctl          out_ctl;
    hse_pkg::t_mem_ctl          mem_ctl;
    logic [IDX_W-1:0]           ra_a;
    logic [IDX_W-1:0]           ra_b;
    logic [IDX_W-1:0]           wa;
    logic [hse_pkg::DATA_W-1:0] wd;
    logic [hse_pkg::DATA_W-1:0] rd_a;
    logic [hse_pkg::DATA_W-1:0] rd_b;
    logic                       out_free;

    logic                       r_out_valid;
    logic [hse_pkg::DATA_W-1:0] r_sorted_value;
    logic                       r_last_out;
    logic                       r_overflowed;

    assign out_free = !r_out_valid || !i_out_stall;

    hse_seq #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_value     (i_value),
        .i_last_item (i_last_item),
        .o_in_stall  (o_in_stall),
        .i_out_free  (out_free),
        .o_out_ctl   (out_ctl),
        .o_mem_ctl   (mem_ctl),
        .o_ra_a      (ra_a),
        .o_ra_b      (ra_b),
        .o_wa        (wa),
        .o_wd        (wd),
        .i_rd_a      (rd_a),
        .i_rd_b      (rd_b)
    );

    hse_mem #(
        .DEPTH (MAX_ELEMENTS),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk  (i_clk),
        .i_ctl  (mem_ctl),
        .i_ra_a (ra_a),
        .i_ra_b (ra_b),
        .i_wa   (wa),
        .i_wd   (wd),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ctl.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ctl.load) begin
            r_sorted_value <= rd_a;
            r_last_out     <= out_ctl.last;
            r_overflowed   <= out_ctl.ovf;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = r_sorted_value;
    assign o_last_out     = r_last_out;
    assign o_overflowed   = r_overflowed;

    `HSE_ASSERT_IMP(a_load_into_free, i_clk, i_rst_n, out_ctl.load, !r_out_valid)

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int CAPACITY = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 20;

    typedef logic signed [hse_pkg::DATA_W-1:0] t_word;

    localparam t_word WORD_MIN = {1'b1, {(hse_pkg::DATA_W-1){1'b0}}};
    localparam t_word WORD_MAX = {1'b0, {(hse_pkg::DATA_W-1){1'b1}}};

    typedef struct {
        t_word value;
        logic  last;
        logic  ovf;
    } t_sorted_beat;

    class ascending_board;
        t_word        set_values[$];
        logic         set_dropped;
        t_sorted_beat expected_sorted[$];
        int           mismatches;
        int           sets_done;
        int           dropped_sets;
        int           beats_out;

        function new();
            set_dropped = 1'b0;
            mismatches = 0;
            sets_done = 0;
            dropped_sets = 0;
            beats_out = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            mismatches++;
        endtask

        // keeps the open set in ascending order; on the last beat the whole
        // set becomes the expected output sequence
        function void note_value(t_word v, logic last);
            t_word        t;
            int           k;
            t_sorted_beat b;
            if (set_values.size() < CAPACITY) begin
                set_values.push_back(v);
                k = set_values.size() - 1;
                while (k > 0 && set_values[k-1] > set_values[k]) begin
                    t = set_values[k-1];
                    set_values[k-1] = set_values[k];
                    set_values[k] = t;
                    k--;
                end
            end else begin
                set_dropped = 1'b1;
            end
            if (last) begin
                for (k = 0; k < set_values.size(); k++) begin
                    b.value = set_values[k];
                    b.last = (k == set_values.size() - 1);
                    b.ovf = set_dropped;
                    expected_sorted.push_back(b);
                end
                sets_done++;
                if (set_dropped)
                    dropped_sets++;
                set_values.delete();
                set_dropped = 1'b0;
            end
        endfunction

        task check_sorted(t_word v, logic last, logic ovf);
            t_sorted_beat exp_beat;
            beats_out++;
            if (expected_sorted.size() == 0) begin
                report($sformatf("unexpected beat value=%0d last=%b ovf=%b", v, last, ovf));
                return;
            end
            exp_beat = expected_sorted.pop_front();
            if (v !== exp_beat.value)
                report($sformatf("sorted_value %0d, want %0d", v, exp_beat.value));
            if (last !== exp_beat.last)
                report($sformatf("last_out %b, want %b (value %0d)", last, exp_beat.last, v));
            if (ovf !== exp_beat.ovf)
                report($sformatf("overflowed %b, want %b (value %0d)", ovf, exp_beat.ovf, v));
        endtask
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  in_valid = 1'b0;
    t_word in_value = '0;
    logic  in_last = 1'b0;
    logic  out_stall = 1'b0;
    logic  in_stall;
    logic  out_valid;
    t_word sorted_value;
    logic  last_out;
    logic  overflowed;

    ascending_board board;
    bit calm = 1'b0;
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;
    int beats_in = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    heap_sort_engine_top #(
        .MAX_ELEMENTS(CAPACITY)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_value(in_value),
        .i_last_item(in_last),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_sorted_value(sorted_value),
        .o_last_out(last_out),
        .o_overflowed(overflowed)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || calm || !stalls_on) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0)
                out_stall <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13);
            out_stall <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall)
            board.check_sorted(sorted_value, last_out, overflowed);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles, %0d sorted beats outstanding",
                     WATCHDOG_LIMIT, board.expected_sorted.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_word pick_value();
        case ($urandom_range(0, 9))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return t_word'($urandom_range(0, 1)) - 1;
            3, 4: return t_word'($urandom_range(0, 15)) - 8;
            default: return t_word'($urandom);
        endcase
    endfunction

    task automatic send_beat(t_word v, logic last);
        if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_value <= v;
        in_last <= last;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        board.note_value(v, last);
        beats_in++;
    endtask

    task automatic send_set(int size);
        for (int k = 0; k < size; k++)
            send_beat(pick_value(), k == size - 1);
    endtask

    // hold the input side until every sorted beat has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (board.expected_sorted.size() != 0);
    endtask

    initial begin
        int  made;
        int  size;
        bit  big_done;
        board = new();
        made = 0;
        big_done = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-element and two-element sets at both extremes
        send_beat(WORD_MAX, 1'b1);
        send_beat(WORD_MIN, 1'b1);
        send_beat(WORD_MAX, 1'b0);
        send_beat(WORD_MIN, 1'b1);
        send_beat(WORD_MIN, 1'b0);
        send_beat(WORD_MAX, 1'b1);
        // mixed signs, alternating bit patterns, duplicates
        send_beat(t_word'(0), 1'b0);
        send_beat(t_word'(-1), 1'b0);
        send_beat(t_word'(1), 1'b0);
        send_beat(WORD_MIN, 1'b0);
        send_beat(WORD_MAX, 1'b0);
        send_beat(t_word'(32'hAAAA_AAAA), 1'b0);
        send_beat(t_word'(32'h5555_5555), 1'b0);
        send_beat(t_word'(1), 1'b0);
        send_beat(WORD_MAX, 1'b0);
        send_beat(WORD_MIN, 1'b1);
        // all equal
        send_beat(t_word'(42), 1'b0);
        send_beat(t_word'(42), 1'b0);
        send_beat(t_word'(42), 1'b1);
        wait_drained();

        while (made < RANDOM_ITEMS) begin
            size = $urandom_range(1, 12);
            if (made >= RANDOM_ITEMS * 3 / 4)
                calm = 1'b1;
            gaps_on = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0)
                wait_drained();
            send_set(size);
            made += size;
            if (!big_done && made >= 8) begin
                // fills the store, then the last beat is dropped
                send_set(CAPACITY + 1);
                big_done = 1'b1;
            end
        end
        in_valid <= 1'b0;

        while (board.expected_sorted.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Covered %0d sets (%0d over capacity) from %0d input beats, %0d sorted beats",
                 board.sets_done, board.dropped_sets, beats_in, board.beats_out);
        $display("Random values with random input gaps and output stalls, calm final stretch");
        if (board.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/hse_pkg.sv
rtl/hse_mem.sv
rtl/hse_seq.sv
rtl/heap_sort_engine_top.sv
tb/testbench.sv
